// ===== hdl/segment_pair_intersection_core_defines.svh =====
// Assertion macros shared by the segment pair intersection RTL.
// No dependencies; modules that assert include this file and must have clk and arst_n.
`ifndef SEGMENT_PAIR_INTERSECTION_CORE_DEFINES_SVH
`define SEGMENT_PAIR_INTERSECTION_CORE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define SPI_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A trigger that implies a consequence at the same clock edge.
`define SPI_ASSERT_IMPLY(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

`endif

// ===== hdl/spi_pkg.sv =====
// Package for the segment pair intersection core: widths, relation codes and beat types.
// No dependencies.
`timescale 1ns / 1ps
package spi_pkg;
	localparam int COORD_BITS      = 24;
	localparam int PARAM_FRAC_BITS = 16;
	localparam int DIFF_W          = COORD_BITS + 1;
	localparam int PROD_W          = 2 * DIFF_W;
	localparam int CROSS_W         = PROD_W + 1;
	localparam int REM_W           = CROSS_W + 1;
	localparam int PARAM_W         = PARAM_FRAC_BITS + 1;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = 2;

	typedef enum logic [1:0] {
		REL_DISJOINT = 2'd0,
		REL_CROSS    = 2'd1,
		REL_PARALLEL = 2'd2
	} rel_t;

	// One classified pair on its way to the dividers.
	typedef struct packed {
		rel_t                      relation;
		logic                      tv;
		logic                      uv;
		logic [CROSS_W-1:0]        den;
		logic signed [CROSS_W-1:0] tn;
		logic signed [CROSS_W-1:0] un;
	} item_t;
endpackage

// ===== hdl/segment_pair_intersection_core.sv =====
// Top level of the segment pair intersection core: front, queue and divider back end.
// Depends on spi_pkg, spi_front, spi_queue, spi_back and the assertion macro header.
`timescale 1ns / 1ps
// Takes one pair of 2D segments per beat and returns one result beat per pair: the
// relation code, and the crossing position along each segment as a Q1.16 fraction with
// its valid flag. A new pair can be pushed every cycle while full is low. A pair passes
// through the front (differences, multipliers, cross products, sign normalization,
// classification) and the 4-entry queue. It then runs through the 17 back stages,
// where each stage yields one quotient bit of the two restoring dividers. The last
// divider stage holds the result shown while empty is low.
module segment_pair_intersection_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [spi_pkg::COORD_BITS-1:0] a_start_x,
	input  logic signed [spi_pkg::COORD_BITS-1:0] a_start_y,
	input  logic signed [spi_pkg::COORD_BITS-1:0] a_end_x,
	input  logic signed [spi_pkg::COORD_BITS-1:0] a_end_y,
	input  logic signed [spi_pkg::COORD_BITS-1:0] b_start_x,
	input  logic signed [spi_pkg::COORD_BITS-1:0] b_start_y,
	input  logic signed [spi_pkg::COORD_BITS-1:0] b_end_x,
	input  logic signed [spi_pkg::COORD_BITS-1:0] b_end_y,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [1:0]                           relation,
	output logic [spi_pkg::PARAM_W-1:0]          self_param,
	output logic                                 self_param_valid,
	output logic [spi_pkg::PARAM_W-1:0]          other_param,
	output logic                                 other_param_valid
);
	import spi_pkg::*;
	`include "segment_pair_intersection_core_defines.svh"

	logic  item_valid, q_full, q_empty, q_rd, res_valid;
	item_t item, head;
	rel_t  res_relation;

	spi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.a_start_x  (a_start_x),
		.a_start_y  (a_start_y),
		.a_end_x    (a_end_x),
		.a_end_y    (a_end_y),
		.b_start_x  (b_start_x),
		.b_start_y  (b_start_y),
		.b_end_x    (b_end_x),
		.b_end_y    (b_end_y),
		.item_valid (item_valid),
		.item       (item),
		.queue_full (q_full)
	);

	spi_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (item_valid),
		.wr_item (item),
		.q_full  (q_full),
		.rd      (q_rd),
		.rd_item (head),
		.q_empty (q_empty)
	);

	spi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head         (head),
		.rd           (q_rd),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_relation (res_relation),
		.res_t        (self_param),
		.res_tv       (self_param_valid),
		.res_u        (other_param),
		.res_uv       (other_param_valid)
	);

	assign empty    = !res_valid;
	assign relation = res_relation;

	`SPI_ASSERT_IMPLY(a_par_novalid, !empty && relation == REL_PARALLEL, !self_param_valid && !other_param_valid, "parallel pair flagged valid")
	`SPI_ASSERT_IMPLY(a_t_range, !empty && self_param_valid, self_param <= PARAM_W'(1 << PARAM_FRAC_BITS), "self_param above one")
	`SPI_ASSERT_IMPLY(a_u_range, !empty && other_param_valid, other_param <= PARAM_W'(1 << PARAM_FRAC_BITS), "other_param above one")
endmodule

// ===== hdl/spi_front.sv =====
// Front part: differences, cross products, sign normalization and classification.
// Depends on spi_pkg.
`timescale 1ns / 1ps
module spi_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [spi_pkg::COORD_BITS-1:0] a_start_x,
	input  logic signed [spi_pkg::COORD_BITS-1:0] a_start_y,
	input  logic signed [spi_pkg::COORD_BITS-1:0] a_end_x,
	input  logic signed [spi_pkg::COORD_BITS-1:0] a_end_y,
	input  logic signed [spi_pkg::COORD_BITS-1:0] b_start_x,
	input  logic signed [spi_pkg::COORD_BITS-1:0] b_start_y,
	input  logic signed [spi_pkg::COORD_BITS-1:0] b_end_x,
	input  logic signed [spi_pkg::COORD_BITS-1:0] b_end_y,
	output logic                                 item_valid,
	output spi_pkg::item_t                       item,
	input  logic                                 queue_full
);
	import spi_pkg::*;

	logic fe;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DIFF_W-1:0]  dax_s1, day_s1, dbx_s1, dby_s1, wx_s1, wy_s1;
	logic signed [PROD_W-1:0]  p_dax_dby_s2, p_day_dbx_s2, p_wx_dby_s2;
	logic signed [PROD_W-1:0]  p_wy_dbx_s2, p_wx_day_s2, p_wy_dax_s2;
	logic signed [CROSS_W-1:0] den_s3, tn_s3, un_s3;
	logic [CROSS_W-1:0]        den_s4;
	logic signed [CROSS_W-1:0] tn_s4, un_s4;
	logic                      straddle_s4;
	item_t                     item_s5;
	logic signed [CROSS_W:0]   side_e;
	logic                      un_pos, den_neg, straddle;
	logic                      den_zero, t_half, u_half, t_closed, u_closed;
	item_t                     cls;

	// The whole front advances unless its last beat cannot enter the queue.
	assign fe   = !v_s5 || !queue_full;
	assign full = !fe;

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (fe) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// The point b_end - a_start enters only through side_e = den - un.
	assign side_e   = {den_s3[CROSS_W-1], den_s3} - {un_s3[CROSS_W-1], un_s3};
	assign un_pos   = !un_s3[CROSS_W-1] && (un_s3 != '0);
	assign den_neg  = den_s3[CROSS_W-1];
	assign straddle = (un_s3 != '0) && (side_e != '0) && (un_pos != side_e[CROSS_W]);

	// Classification against the sign-normalized, non-negative denominator.
	assign den_zero = (den_s4 == '0);
	assign t_half   = !tn_s4[CROSS_W-1] && (CROSS_W'(tn_s4) < den_s4);
	assign u_half   = !un_s4[CROSS_W-1] && (CROSS_W'(un_s4) < den_s4);
	assign t_closed = !tn_s4[CROSS_W-1] && (CROSS_W'(tn_s4) <= den_s4);
	assign u_closed = !un_s4[CROSS_W-1] && (CROSS_W'(un_s4) <= den_s4);

	always_comb begin
		cls.den = den_s4;
		cls.tn  = tn_s4;
		cls.un  = un_s4;
		cls.tv  = straddle_s4 && !den_zero && t_closed;
		cls.uv  = straddle_s4 && !den_zero && u_closed;
		if (den_zero) begin
			cls.relation = REL_PARALLEL;
		end else if (t_half && u_half) begin
			cls.relation = REL_CROSS;
		end else begin
			cls.relation = REL_DISJOINT;
		end
	end

	// Payload stages: differences, products, crosses, normalization, class.
	always_ff @(posedge clk) begin
		if (fe) begin
			dax_s1 <= DIFF_W'(a_end_x) - DIFF_W'(a_start_x);
			day_s1 <= DIFF_W'(a_end_y) - DIFF_W'(a_start_y);
			dbx_s1 <= DIFF_W'(b_end_x) - DIFF_W'(b_start_x);
			dby_s1 <= DIFF_W'(b_end_y) - DIFF_W'(b_start_y);
			wx_s1  <= DIFF_W'(b_start_x) - DIFF_W'(a_start_x);
			wy_s1  <= DIFF_W'(b_start_y) - DIFF_W'(a_start_y);

			p_dax_dby_s2 <= dax_s1 * dby_s1;
			p_day_dbx_s2 <= day_s1 * dbx_s1;
			p_wx_dby_s2  <= wx_s1 * dby_s1;
			p_wy_dbx_s2  <= wy_s1 * dbx_s1;
			p_wx_day_s2  <= wx_s1 * day_s1;
			p_wy_dax_s2  <= wy_s1 * dax_s1;

			den_s3 <= CROSS_W'(p_dax_dby_s2) - CROSS_W'(p_day_dbx_s2);
			tn_s3  <= CROSS_W'(p_wx_dby_s2) - CROSS_W'(p_wy_dbx_s2);
			un_s3  <= CROSS_W'(p_wx_day_s2) - CROSS_W'(p_wy_dax_s2);

			den_s4      <= den_neg ? CROSS_W'(-den_s3) : CROSS_W'(den_s3);
			tn_s4       <= den_neg ? -tn_s3 : tn_s3;
			un_s4       <= den_neg ? -un_s3 : un_s3;
			straddle_s4 <= straddle;

			item_s5 <= cls;
		end
	end

	assign item_valid = v_s5 && !queue_full;
	assign item       = item_s5;
endmodule

// ===== hdl/spi_queue.sv =====
// Short queue of classified beats between the front and the dividers.
// Depends on spi_pkg and the assertion macro header.
`timescale 1ns / 1ps
module spi_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  spi_pkg::item_t wr_item,
	output logic           q_full,
	input  logic           rd,
	output spi_pkg::item_t rd_item,
	output logic           q_empty
);
	import spi_pkg::*;
	`include "segment_pair_intersection_core_defines.svh"

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_wr, do_rd;

	assign q_full  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rd_item = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_item;
		end
	end

	`SPI_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= (QPTR_W + 1)'(QUEUE_DEPTH), "queue overfilled")
	`SPI_ASSERT_IMPLY(a_ptr_match, q_empty || q_full, wp_q == rp_q, "queue pointers disagree")
endmodule

// ===== hdl/spi_back.sv =====
// Back part: two restoring dividers, one quotient bit per stage, for both parameters.
// Depends on spi_pkg.
`timescale 1ns / 1ps
module spi_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  spi_pkg::item_t                head,
	output logic                          rd,
	input  logic                          pop,
	output logic                          res_valid,
	output spi_pkg::rel_t                 res_relation,
	output logic [spi_pkg::PARAM_W-1:0]   res_t,
	output logic                          res_tv,
	output logic [spi_pkg::PARAM_W-1:0]   res_u,
	output logic                          res_uv
);
	import spi_pkg::*;

	typedef struct packed {
		rel_t               relation;
		logic               tv;
		logic               uv;
		logic [REM_W-1:0]   d;
		logic [REM_W-1:0]   rt;
		logic [REM_W-1:0]   ru;
		logic [PARAM_W-1:0] qt;
		logic [PARAM_W-1:0] qu;
	} bstage_t;

	localparam int NSTAGE = PARAM_FRAC_BITS + 1;

	bstage_t st_q [NSTAGE];
	logic    v_q  [NSTAGE];
	bstage_t nx   [NSTAGE];
	logic    be;

	// The divider chain moves as one; the last stage is the result register.
	assign be = !v_q[NSTAGE-1] || pop;
	assign rd = be && !q_empty;

	// Integer step: a numerator equal to the denominator gives a leading one.
	always_comb begin
		logic [REM_W-1:0] d0, t0, u0;
		d0 = REM_W'(head.den);
		t0 = REM_W'(unsigned'(head.tn));
		u0 = REM_W'(unsigned'(head.un));
		nx[0].relation = head.relation;
		nx[0].tv       = head.tv;
		nx[0].uv       = head.uv;
		nx[0].d        = d0;
		nx[0].rt       = (t0 >= d0) ? t0 - d0 : t0;
		nx[0].ru       = (u0 >= d0) ? u0 - d0 : u0;
		nx[0].qt       = PARAM_W'(t0 >= d0);
		nx[0].qu       = PARAM_W'(u0 >= d0);
	end

	// Fraction steps: shift the remainder, compare, subtract.
	for (genvar k = 1; k < NSTAGE; k++) begin : g_step
		always_comb begin
			logic [REM_W-1:0] ts, us;
			logic             tb, ub;
			ts = {st_q[k-1].rt[REM_W-2:0], 1'b0};
			us = {st_q[k-1].ru[REM_W-2:0], 1'b0};
			tb = (ts >= st_q[k-1].d);
			ub = (us >= st_q[k-1].d);
			nx[k]    = st_q[k-1];
			nx[k].rt = tb ? ts - st_q[k-1].d : ts;
			nx[k].ru = ub ? us - st_q[k-1].d : us;
			nx[k].qt = {st_q[k-1].qt[PARAM_W-2:0], tb};
			nx[k].qu = {st_q[k-1].qu[PARAM_W-2:0], ub};
		end
	end

	// Stage registers.
	for (genvar k = 0; k < NSTAGE; k++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (be) begin
				v_q[k] <= (k == 0) ? rd : v_q[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (be) begin
				st_q[k] <= nx[k];
			end
		end
	end

	// An invalid parameter reads as zero.
	assign res_valid    = v_q[NSTAGE-1];
	assign res_relation = st_q[NSTAGE-1].relation;
	assign res_tv       = st_q[NSTAGE-1].tv;
	assign res_uv       = st_q[NSTAGE-1].uv;
	assign res_t        = st_q[NSTAGE-1].tv ? st_q[NSTAGE-1].qt : '0;
	assign res_u        = st_q[NSTAGE-1].uv ? st_q[NSTAGE-1].qu : '0;
endmodule

// ===== dv/segment_pair_intersection_checker.sv =====
// Checker for the segment pair intersection core: watches both queue ports and predicts results.
// Depends on spi_pkg for the widths and the relation codes.
`timescale 1ns / 1ps
module segment_pair_intersection_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	input  logic                                  full,
	input  logic signed [spi_pkg::COORD_BITS-1:0] a_start_x,
	input  logic signed [spi_pkg::COORD_BITS-1:0] a_start_y,
	input  logic signed [spi_pkg::COORD_BITS-1:0] a_end_x,
	input  logic signed [spi_pkg::COORD_BITS-1:0] a_end_y,
	input  logic signed [spi_pkg::COORD_BITS-1:0] b_start_x,
	input  logic signed [spi_pkg::COORD_BITS-1:0] b_start_y,
	input  logic signed [spi_pkg::COORD_BITS-1:0] b_end_x,
	input  logic signed [spi_pkg::COORD_BITS-1:0] b_end_y,
	input  logic                                  empty,
	input  logic                                  pop,
	input  logic [1:0]                            relation,
	input  logic [spi_pkg::PARAM_W-1:0]           self_param,
	input  logic                                  self_param_valid,
	input  logic [spi_pkg::PARAM_W-1:0]           other_param,
	input  logic                                  other_param_valid,
	output int                                    fail_count,
	output int                                    pending
);
	import spi_pkg::*;

	typedef struct {
		rel_t               rel;
		logic [PARAM_W-1:0] t_frac;
		logic               t_ok;
		logic [PARAM_W-1:0] u_frac;
		logic               u_ok;
	} crossing_t;

	crossing_t expected_crossings[$];

	// Restoring division giving floor(n * 2^PARAM_FRAC_BITS / d) for 0 <= n <= d.
	function automatic logic [PARAM_W-1:0] frac_quotient(longint n, longint d);
		logic [PARAM_W-1:0] q;
		q = '0;
		if (n >= d) begin
			q = 1;
			n = n - d;
		end
		for (int i = 0; i < PARAM_FRAC_BITS; i++) begin
			n = n <<< 1;
			q = q << 1;
			if (n >= d) begin
				n = n - d;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic longint cross2(longint px, longint py, longint qx, longint qy);
		return px * qy - py * qx;
	endfunction

	// Parametric intersection of the pair currently on the input ports.
	function automatic crossing_t solve_pair();
		crossing_t r;
		longint asx, asy, dax, day, dbx, dby, wx, wy, px, py;
		longint den, tn, un, side_s, side_e;
		logic straddle;
		asx = a_start_x;
		asy = a_start_y;
		dax = longint'(a_end_x) - asx;
		day = longint'(a_end_y) - asy;
		dbx = longint'(b_end_x) - longint'(b_start_x);
		dby = longint'(b_end_y) - longint'(b_start_y);
		wx = longint'(b_start_x) - asx;
		wy = longint'(b_start_y) - asy;
		px = longint'(b_end_x) - asx;
		py = longint'(b_end_y) - asy;
		den = cross2(dax, day, dbx, dby);
		tn = cross2(wx, wy, dbx, dby);
		un = cross2(wx, wy, dax, day);
		side_s = cross2(dax, day, wx, wy);
		side_e = cross2(dax, day, px, py);
		straddle = side_s != 0 && side_e != 0 && ((side_s < 0) != (side_e < 0));
		if (den < 0) begin
			den = -den;
			tn = -tn;
			un = -un;
		end
		if (den == 0)
			r.rel = REL_PARALLEL;
		else if (tn >= 0 && tn < den && un >= 0 && un < den)
			r.rel = REL_CROSS;
		else
			r.rel = REL_DISJOINT;
		r.t_ok = straddle && den != 0 && tn >= 0 && tn <= den;
		r.u_ok = straddle && den != 0 && un >= 0 && un <= den;
		r.t_frac = r.t_ok ? frac_quotient(tn, den) : '0;
		r.u_frac = r.u_ok ? frac_quotient(un, den) : '0;
		return r;
	endfunction

	assign pending = expected_crossings.size();

	// Predict on every accepted input beat, compare on every accepted result beat.
	always @(posedge clk or negedge arst_n) begin
		crossing_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (push && !full)
				expected_crossings.push_back(solve_pair());
			if (pop && !empty) begin
				if (expected_crossings.size() == 0) begin
					$error("result beat with nothing expected");
					errs++;
				end else begin
					e = expected_crossings.pop_front();
					if (relation !== e.rel) begin
						$error("relation: expected %0d, actual %0d", e.rel, relation);
						errs++;
					end
					if (self_param !== e.t_frac) begin
						$error("self_param: expected %0d, actual %0d", e.t_frac, self_param);
						errs++;
					end
					if (self_param_valid !== e.t_ok) begin
						$error("self_param_valid: expected %0d, actual %0d", e.t_ok,
							self_param_valid);
						errs++;
					end
					if (other_param !== e.u_frac) begin
						$error("other_param: expected %0d, actual %0d", e.u_frac, other_param);
						errs++;
					end
					if (other_param_valid !== e.u_ok) begin
						$error("other_param_valid: expected %0d, actual %0d", e.u_ok,
							other_param_valid);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end
endmodule

// ===== dv/tb_segment_pair_intersection_core.sv =====
// Testbench top for the segment pair intersection core: clock, reset, stimulus and verdict.
// Depends on spi_pkg, segment_pair_intersection_core and segment_pair_intersection_checker.
`timescale 1ns / 1ps
module tb_segment_pair_intersection_core;
	import spi_pkg::*;

	localparam int  RANDOM_PAIRS = 1730;
	localparam int  CALM_PAIRS   = 250;
	localparam int  CYCLE_LIMIT  = 200000;
	localparam int  COORD_MAX    = 8388607;
	localparam int  COORD_MIN    = -8388608;
	localparam int  ONE          = 256;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic signed [COORD_BITS-1:0] a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
	logic signed [COORD_BITS-1:0] b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
	logic [1:0]         relation;
	logic [PARAM_W-1:0] self_param, other_param;
	logic               self_param_valid, other_param_valid;
	int  fail_count, pending;
	int  pairs_sent = 0;
	logic calm = 1'b0;
	int  cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	segment_pair_intersection_core u_dut (.*);

	segment_pair_intersection_checker u_checker (.*);

	// Hard limit on the run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: random pop bursts, one long hold-off to back up the core.
	initial begin
		int gap;
		int hold;
		logic held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && pairs_sent >= 400) begin
				held = 1'b1;
				pop <= 1'b0;
				hold = $urandom_range(300, 200);
				repeat (hold) @(posedge clk);
			end else if (!calm && $urandom_range(3) == 0) begin
				pop <= 1'b0;
				gap = $urandom_range(3, 1);
				repeat (gap - 1) @(posedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Offers one pair and holds it until the core takes the beat.
	task automatic send_pair(int ax0, int ay0, int ax1, int ay1,
			int bx0, int by0, int bx1, int by1);
		int gap;
		push <= 1'b1;
		a_start_x <= COORD_BITS'(ax0);
		a_start_y <= COORD_BITS'(ay0);
		a_end_x <= COORD_BITS'(ax1);
		a_end_y <= COORD_BITS'(ay1);
		b_start_x <= COORD_BITS'(bx0);
		b_start_y <= COORD_BITS'(by0);
		b_end_x <= COORD_BITS'(bx1);
		b_end_y <= COORD_BITS'(by1);
		do @(posedge clk); while (full);
		pairs_sent++;
		if (!calm && $urandom_range(3) == 0) begin
			push <= 1'b0;
			gap = $urandom_range(3, 1);
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic int any_coord();
		return int'(signed'(COORD_BITS'($urandom)));
	endfunction

	function automatic int near_coord();
		return $urandom_range(2048) - 1024;
	endfunction

	initial begin
		int c[8];
		int kind;
		int sel;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs: degenerate, crossing, parallel, exact ends and extremes.
		send_pair(0, 0, 0, 0, 0, 0, 0, 0);
		send_pair(0, 0, ONE, ONE, 0, ONE, ONE, 0);
		send_pair(0, 0, ONE, ONE, ONE, 0, 0, ONE);
		send_pair(0, 0, ONE, 0, 0, ONE, ONE, ONE);
		send_pair(0, 0, ONE, 0, ONE, -ONE, ONE, ONE);
		send_pair(0, 0, ONE, 0, 0, -ONE, 0, ONE);
		send_pair(0, 0, ONE, 0, 128, 0, 128, ONE);
		send_pair(0, 0, ONE, 0, 2 * ONE, -ONE, 2 * ONE, ONE);
		send_pair(0, 0, ONE, 0, -ONE, -ONE, -ONE, ONE);
		send_pair(0, 0, ONE, 0, 255, -ONE, 255, ONE);
		send_pair(0, 0, 3, 0, 1, -1, 1, 2);
		send_pair(0, 0, 2 * ONE, 0, ONE, 0, 3 * ONE, 0);
		send_pair(0, 0, ONE, 0, 128, ONE, 128, 2 * ONE);
		send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
			COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
		send_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
		send_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
		send_pair(COORD_MIN, 0, COORD_MAX, 0, 0, COORD_MIN, 0, COORD_MAX);
		send_pair(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
			COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
		send_pair(-1, -1, 1, 1, -1, 1, 1, -1);

		// Random pairs: mostly near the origin so crossings are common.
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			if (i == RANDOM_PAIRS - CALM_PAIRS)
				calm = 1'b1;
			kind = $urandom_range(9);
			foreach (c[k])
				c[k] = (kind < 6) ? near_coord() : any_coord();
			// Occasionally share or mirror endpoints to hit the boundary cases.
			if (kind == 9) begin
				sel = $urandom_range(1) * 2;
				c[4] = c[sel];
				c[5] = c[sel + 1];
				if ($urandom_range(1))
					{c[6], c[7]} = {2 * c[2] - c[0], 2 * c[3] - c[1]};
			end
			send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
		end
		push <= 1'b0;

		// Drain, then allow the pipeline latency to pass.
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
